// ===== design/tcd_pkg.sv =====
// Shared constants and hash step for the tile change detector.
`default_nettype none

package tcd_pkg;

	localparam logic [31:0] HASH_PRIME  = 32'h0100_0193;
	localparam logic [31:0] STORE_RESET = 32'h0000_00ff;

	// h * HASH_PRIME mod 2^32 as shift-add, then fold in the word
	function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [31:0] w);
		logic [31:0] p;
		begin
			p = h + (h << 1) + (h << 4) + (h << 7) + (h << 8) + (h << 24);
			hash_step = p ^ w;
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/tcd_hash_store.sv =====
// Per-tile digest memory with reset sweep, read-old-on-write port.
`default_nettype none

module tcd_hash_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_en,
	input  wire logic [AW-1:0] addr,
	input  wire logic [31:0]   wr_data,
	output logic      [31:0]   rd_data,
	output logic               busy
);

	logic [31:0]   mem [DEPTH];
	logic [AW-1:0] clr_idx_q;
	logic          busy_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_word;

	assign busy    = busy_q;
	assign wr_en   = busy_q || req_en;
	assign wr_addr = busy_q ? clr_idx_q : addr;
	assign wr_word = busy_q ? tcd_pkg::STORE_RESET : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (req_en) begin
			rd_data <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/tile_change_detector_unit.sv =====
// Tile change detector: running multiply-xor hash per tile, compared with the stored digest.
// One request is taken every clock cycle unless tile_stall is high; the running hash updates
// as each word is taken. A last word's result passes through the stage-1 register into the
// output register. The digest memory is read and rewritten on the same edge that takes
// the last word, so last words of the same tile can follow each other back to back.
// After reset the memory is swept to 0x000000ff, during which tile_stall stays high.
`default_nettype none

module tile_change_detector_unit #(
	parameter int TILE_COUNT = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tile_valid,
	output logic             tile_stall,
	input  wire logic [11:0] tile_index,
	input  wire logic [31:0] pixel_word,
	input  wire logic        last_word,
	output logic             digest_valid,
	input  wire logic        digest_stall,
	output logic [11:0]      done_tile,
	output logic [31:0]      tile_digest,
	output logic             changed
);

	localparam int AW = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;

	logic          accept;
	logic          in_range;
	logic [31:0]   next_hash;
	logic [31:0]   running_hash_q;
	logic          store_busy;
	logic [31:0]   prev_digest;
	logic          valid_s1;
	logic [11:0]   idx_s1;
	logic [31:0]   digest_s1;
	logic          in_range_s1;
	logic          out_adv;
	logic          s1_load;
	logic          out_valid_q;
	logic [11:0]   done_tile_q;
	logic [31:0]   tile_digest_q;
	logic          changed_q;

	assign out_adv    = !out_valid_q || !digest_stall;
	assign s1_load    = !valid_s1 || out_adv;
	assign tile_stall = store_busy || (valid_s1 && !out_adv);
	assign accept     = tile_valid && !tile_stall;
	assign in_range   = {5'b0, tile_index} < 17'(TILE_COUNT);
	assign next_hash  = tcd_pkg::hash_step(running_hash_q, pixel_word);

	tcd_hash_store #(
		.DEPTH (TILE_COUNT),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_en  (accept && last_word && in_range),
		.addr    (AW'(tile_index)),
		.wr_data (next_hash),
		.rd_data (prev_digest),
		.busy    (store_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash_q <= '0;
		end else if (accept) begin
			running_hash_q <= last_word ? '0 : next_hash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= accept && last_word;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_word) begin
			idx_s1      <= tile_index;
			digest_s1   <= next_hash;
			in_range_s1 <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			done_tile_q   <= idx_s1;
			tile_digest_q <= digest_s1;
			changed_q     <= !in_range_s1 || (prev_digest != digest_s1);
		end
	end

	assign digest_valid = out_valid_q;
	assign done_tile    = done_tile_q;
	assign tile_digest  = tile_digest_q;
	assign changed      = changed_q;

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		store_busy |-> tile_stall)
		else $error("request taken during store sweep");

	a_hash_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(tile_valid && !tile_stall && last_word) |=> (running_hash_q == 32'h0))
		else $error("running hash not cleared after last word");

	a_out_of_range_changed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ({5'b0, done_tile_q} >= 17'(TILE_COUNT))) |-> changed_q)
		else $error("out-of-range tile reported unchanged");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the tile change detector: queued tile words, hash predictor and result checker.
module tb;

	localparam int TILES = 4096;

	typedef struct packed {
		logic [11:0] idx;
		logic [31:0] word;
		logic        last;
	} tile_req_t;

	typedef struct packed {
		logic [11:0] tile;
		logic [31:0] digest;
		logic        changed;
	} tile_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        tile_valid = 1'b0;
	logic        tile_stall;
	logic [11:0] tile_index = '0;
	logic [31:0] pixel_word = '0;
	logic        last_word = 1'b0;
	logic        digest_valid;
	logic        digest_stall = 1'b0;
	logic [11:0] done_tile;
	logic [31:0] tile_digest;
	logic        changed;

	tile_req_t    pending[$];
	tile_result_t digest_due[$];
	logic [31:0]  stored_digest [TILES];
	logic [31:0]  hash_acc = '0;
	int           taken_count = 0;
	int           fault_count = 0;
	bit           req_taken = 1'b0;

	tile_change_detector_unit #(.TILE_COUNT(TILES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.tile_valid(tile_valid),
		.tile_stall(tile_stall),
		.tile_index(tile_index),
		.pixel_word(pixel_word),
		.last_word(last_word),
		.digest_valid(digest_valid),
		.digest_stall(digest_stall),
		.done_tile(done_tile),
		.tile_digest(tile_digest),
		.changed(changed)
	);

	always #5 clk = ~clk;

	function automatic bit quiet_stretch();
		return taken_count >= 150 && taken_count < 300;
	endfunction

	task automatic add_word(input logic [11:0] idx, input logic [31:0] word, input logic last);
		pending.push_back({idx, word, last});
	endtask

	task automatic absorb_word(input tile_req_t r);
		logic [31:0]  h;
		tile_result_t res;
		h = (hash_acc * tcd_pkg::HASH_PRIME) ^ r.word;
		hash_acc = h;
		if (r.last) begin
			res.tile = r.idx;
			res.digest = h;
			if (int'(r.idx) < TILES) begin
				res.changed = (h != stored_digest[r.idx]);
				stored_digest[r.idx] = h;
			end else begin
				res.changed = 1'b1;
			end
			digest_due.push_back(res);
			hash_acc = '0;
		end
	endtask

	always @(posedge clk) begin
		req_taken <= arst_n && tile_valid && !tile_stall;
		if (arst_n && tile_valid && !tile_stall) begin
			absorb_word({tile_index, pixel_word, last_word});
			taken_count = taken_count + 1;
		end
	end

	always @(negedge clk) begin
		tile_req_t r;
		if (arst_n && (!tile_valid || req_taken)) begin
			if (pending.size() != 0 && (quiet_stretch() || $urandom_range(99) >= 6)) begin
				r = pending.pop_front();
				tile_valid <= 1'b1;
				tile_index <= r.idx;
				pixel_word <= r.word;
				last_word <= r.last;
			end else begin
				tile_valid <= 1'b0;
			end
		end
		digest_stall <= arst_n && !quiet_stretch() && ($urandom_range(99) < 6);
	end

	always @(posedge clk) begin
		tile_result_t want;
		if (arst_n && digest_valid && !digest_stall) begin
			if (digest_due.size() == 0) begin
				$error("result for tile %0d with none pending", done_tile);
				fault_count++;
			end else begin
				want = digest_due.pop_front();
				if (done_tile !== want.tile) begin
					$error("done_tile: expected %0d, got %0d", want.tile, done_tile);
					fault_count++;
				end
				if (tile_digest !== want.digest) begin
					$error("tile_digest: expected %h, got %h", want.digest, tile_digest);
					fault_count++;
				end
				if (changed !== want.changed) begin
					$error("changed: expected %b, got %b", want.changed, changed);
					fault_count++;
				end
			end
		end
	end

	initial begin
		logic [11:0] pool_idx [8];
		logic [31:0] saved [8][8];
		int          saved_len [8];
		int          queued;
		int          slot;
		int          len;
		logic [11:0] idx;
		logic [31:0] word;
		bit          replay;

		foreach (stored_digest[i]) stored_digest[i] = tcd_pkg::STORE_RESET;
		foreach (pool_idx[k]) begin
			pool_idx[k] = 12'($urandom_range(4095));
			saved_len[k] = 0;
		end
		pool_idx[0] = 12'd0;
		pool_idx[7] = 12'd4095;

		// single-word tiles, reset value of the store, repeated content
		add_word(12'd0, 32'h0000_0000, 1'b1);
		add_word(12'd0, 32'h0000_0000, 1'b1);
		add_word(12'd4095, tcd_pkg::STORE_RESET, 1'b1);
		add_word(12'd4095, 32'hffff_ffff, 1'b1);
		add_word(12'd5, 32'hffff_ffff, 1'b0);
		add_word(12'd5, 32'h0000_0000, 1'b0);
		add_word(12'd5, 32'h8000_0000, 1'b0);
		add_word(12'd5, 32'h1234_5678, 1'b1);
		add_word(12'd5, 32'hffff_ffff, 1'b0);
		add_word(12'd5, 32'h0000_0000, 1'b0);
		add_word(12'd5, 32'h8000_0000, 1'b0);
		add_word(12'd5, 32'h1234_5678, 1'b1);
		// index hops inside one tile
		add_word(12'd7, 32'ha5a5_a5a5, 1'b0);
		add_word(12'd9, 32'h5a5a_5a5a, 1'b0);
		add_word(12'd2048, 32'h0000_0001, 1'b1);
		// back-to-back last words of one tile
		add_word(12'd3, 32'hdead_beef, 1'b1);
		add_word(12'd3, 32'hdead_beef, 1'b1);
		add_word(12'd3, 32'h0000_0001, 1'b1);
		queued = 18;

		while (queued < 500) begin
			slot = $urandom_range(7);
			idx = ($urandom_range(9) < 6) ? pool_idx[slot] : 12'($urandom_range(4095));
			replay = (idx == pool_idx[slot]) && (saved_len[slot] != 0) && ($urandom_range(2) == 0);
			len = replay ? saved_len[slot] : $urandom_range(1, 8);
			for (int k = 0; k < len; k++) begin
				if (replay) begin
					word = saved[slot][k];
				end else begin
					case ($urandom_range(11))
						0: word = 32'h0000_0000;
						1: word = 32'hffff_ffff;
						2: word = 32'h8000_0000;
						3: word = 32'h0000_0001;
						default: word = $urandom;
					endcase
					if (idx == pool_idx[slot]) saved[slot][k] = word;
				end
				if (k != len - 1 && $urandom_range(11) == 0)
					add_word(12'($urandom_range(4095)), word, 1'b0);
				else
					add_word(idx, word, k == len - 1);
			end
			if (!replay && idx == pool_idx[slot]) saved_len[slot] = len;
			queued += len;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (pending.size() != 0 || tile_valid || digest_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fault_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/tcd_pkg.sv
design/tcd_hash_store.sv
design/tile_change_detector_unit.sv
sim/tb.sv
